/* src/thqa_pkg.sv */
// ----------------------------------------------------------------------------
// thqa_pkg: shared constants and types
// Sizes, register indexes, reject codes and the controller/datapath links
// of the temperature/humidity qualifier averager.
// ----------------------------------------------------------------------------
`default_nettype none

package thqa_pkg;

    // averaging window and error allowance
    localparam int WINDOW      = 8;
    localparam int ERROR_LIMIT = 3;

    localparam int SLOTW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNTW  = $clog2(WINDOW + 1);
    localparam int TSUMW = 11 + $clog2(WINDOW) + 1;
    localparam int HSUMW = 10 + $clog2(WINDOW);

    // rounding divider: (2*|sum| + n) / (2*n)
    localparam int DNUMW = TSUMW + 1;
    localparam int DENW  = CNTW + 1;
    localparam int DCNTW = $clog2(DNUMW);

    localparam int CFG_IDXW  = 3;
    localparam int CFG_DATAW = 11;

    localparam logic [CFG_IDXW-1:0] CFG_TEMP_OFFSET  = 3'd0;
    localparam logic [CFG_IDXW-1:0] CFG_HUMID_OFFSET = 3'd1;
    localparam logic [CFG_IDXW-1:0] CFG_TEMP_LOWEST  = 3'd2;
    localparam logic [CFG_IDXW-1:0] CFG_TEMP_HIGHEST = 3'd3;
    localparam logic [CFG_IDXW-1:0] CFG_HUMID_LOWEST = 3'd4;
    localparam logic [CFG_IDXW-1:0] CFG_HUMID_HIGHEST = 3'd5;
    localparam logic [CFG_IDXW-1:0] CFG_TEMP_STEP    = 3'd6;
    localparam logic [CFG_IDXW-1:0] CFG_HUMID_STEP   = 3'd7;

    localparam logic signed [10:0] TEMP_LOWEST_RST  = -11'sd400;
    localparam logic signed [10:0] TEMP_HIGHEST_RST = 11'sd800;
    localparam logic [9:0]         HUMID_LOWEST_RST = 10'd0;
    localparam logic [9:0]         HUMID_HIGHEST_RST = 10'd1000;
    localparam logic [10:0]        TEMP_STEP_RST    = 11'd50;
    localparam logic [10:0]        HUMID_STEP_RST   = 11'd200;

    localparam logic [9:0] HUMID_MAX = 10'd1000;

    localparam logic [2:0] RSN_OK         = 3'd0;
    localparam logic [2:0] RSN_READ_FAIL  = 3'd1;
    localparam logic [2:0] RSN_TEMP_RANGE = 3'd2;
    localparam logic [2:0] RSN_HUMID_RANGE = 3'd3;
    localparam logic [2:0] RSN_TEMP_STEP  = 3'd4;
    localparam logic [2:0] RSN_HUMID_STEP = 3'd5;

    typedef struct packed {
        logic capture;
        logic check;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* src/temp_humidity_qualifier_averager.sv */
// ----------------------------------------------------------------------------
// temp_humidity_qualifier_averager: reading qualifier with moving average
// Applies offsets, range and step checks to each reading and reports the
// rounded mean of the last accepted readings, or the held value.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    read_failed, raw_temp, raw_humid
//  output    out        o_valid / i_stall    temp_out, humid_out, value_present,
//                                            reading_valid, reject_reason, error_run
//  config    in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
//  an accepted reading passes capture, check, load, the bit-serial rounding
//  divide by the fill count and finish; a rejected one skips load and divide
//  o_stall is high from the cycle after a transaction until its result has
//  moved into the output register, which then waits on i_stall on its own
//  synchronous active-low reset; no clearing pass, the ring is read only
//  where it has been written
//
`default_nettype none

module temp_humidity_qualifier_averager
    import thqa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDXW-1:0]  i_cfg_index,
    input  wire logic [CFG_DATAW-1:0] i_cfg_wdata,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_read_failed,
    input  wire logic signed [10:0]   i_raw_temp,
    input  wire logic [9:0]           i_raw_humid,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [10:0]        o_temp_out,
    output logic [9:0]                o_humid_out,
    output logic                      o_value_present,
    output logic                      o_reading_valid,
    output logic [2:0]                o_reject_reason,
    output logic [7:0]                o_error_run
);

    t_cmd cmd;
    t_sts sts;

    thqa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    thqa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_read_failed   (i_read_failed),
        .i_raw_temp      (i_raw_temp),
        .i_raw_humid     (i_raw_humid),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_temp_out      (o_temp_out),
        .o_humid_out     (o_humid_out),
        .o_value_present (o_value_present),
        .o_reading_valid (o_reading_valid),
        .o_reject_reason (o_reject_reason),
        .o_error_run     (o_error_run)
    );

endmodule

`default_nettype wire

/* src/thqa_div.sv */
// ----------------------------------------------------------------------------
// thqa_div: restoring divider
// Unsigned quotient, one bit per step, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module thqa_div
    import thqa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_load,
    input  wire logic             i_step,
    input  wire logic [DNUMW-1:0] i_num,
    input  wire logic [DENW-1:0]  i_den,
    output logic      [DNUMW-1:0] o_quot
);

    logic [DENW-1:0]  r_rem;
    logic [DNUMW-1:0] r_quot;
    logic [DENW-1:0]  r_den;

    logic [DENW:0]   trial;
    logic            q_bit;
    logic [DENW:0]   diff;
    logic [DENW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quot[DNUMW-1]};
        q_bit = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
        n_rem = q_bit ? diff[DENW-1:0] : trial[DENW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (i_step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[DNUMW-2:0], q_bit};
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* src/thqa_ctrl.sv */
// ----------------------------------------------------------------------------
// thqa_ctrl: sequencing state machine
// Walks one reading through capture, qualification, divide (accepted readings only) and output.
// ----------------------------------------------------------------------------
`default_nettype none

module thqa_ctrl
    import thqa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    localparam logic [DCNTW-1:0] DIV_LAST = DCNTW'(DNUMW - 1);

    t_state           r_state, n_state;
    logic [DCNTW-1:0] r_cnt, n_cnt;
    t_cmd             cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                n_state   = i_sts.pass ? ST_LOAD : ST_FIN;
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_cmd   = cmd;

    // a result is only pushed when the output register can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> i_sts.out_free)
        else $error("finish issued while output register busy");

    // the divide starts from a zeroed step count after a load
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state == ST_DIV) && (r_cnt == '0))
        else $error("divide did not start from zero");

    // state register stays one-hot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule

`default_nettype wire

/* src/thqa_dp.sv */
// ----------------------------------------------------------------------------
// thqa_dp: qualifier and averaging datapath
// Offsets, range and step checks, sample ring, running sums, rounding
// dividers, error run counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module thqa_dp
    import thqa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDXW-1:0]  i_cfg_index,
    input  wire logic [CFG_DATAW-1:0] i_cfg_wdata,
    input  wire logic                 i_read_failed,
    input  wire logic signed [10:0]   i_raw_temp,
    input  wire logic [9:0]           i_raw_humid,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output logic signed [10:0]        o_temp_out,
    output logic [9:0]                o_humid_out,
    output logic                      o_value_present,
    output logic                      o_reading_valid,
    output logic [2:0]                o_reject_reason,
    output logic [7:0]                o_error_run
);

    // configuration
    logic signed [8:0]  r_temp_offset, r_humid_offset;
    logic signed [10:0] r_temp_lowest, r_temp_highest;
    logic [9:0]         r_humid_lowest, r_humid_highest;
    logic [10:0]        r_temp_step, r_humid_step;

    // item and running state
    logic               r_failed;
    logic signed [11:0] r_t, r_h;
    logic signed [10:0] r_old_t;
    logic [9:0]         r_old_h;
    logic signed [10:0] r_temp_ring [WINDOW];
    logic [9:0]         r_humid_ring [WINDOW];
    logic signed [TSUMW-1:0] r_t_sum;
    logic [HSUMW-1:0]   r_h_sum;
    logic [SLOTW-1:0]   r_slot;
    logic [CNTW-1:0]    r_fill;
    logic signed [10:0] r_prev_t;
    logic [9:0]         r_prev_h;
    logic               r_have_prev;
    logic [7:0]         r_err;
    logic [2:0]         r_reason;
    logic               r_pass;
    logic               r_t_neg;

    // output register
    logic               r_out_valid;
    logic signed [10:0] r_o_temp;
    logic [9:0]         r_o_humid;
    logic               r_o_present;
    logic               r_o_rvalid;
    logic [2:0]         r_o_reason;
    logic [7:0]         r_o_err;

    logic signed [11:0] t_in, h_in;
    logic signed [11:0] t_lo, t_hi, h_lo, h_hi;
    logic signed [12:0] dt, dh;
    logic [12:0]        adt, adh;
    logic [2:0]         reason;
    logic [9:0]         h_clamp;
    logic               full;
    logic signed [TSUMW-1:0] t_sum_n;
    logic [HSUMW-1:0]   h_sum_n;
    logic [SLOTW-1:0]   slot_n;
    logic [TSUMW-1:0]   t_mag;
    logic [DNUMW-1:0]   num_t, num_h;
    logic [DENW-1:0]    den;
    logic [DNUMW-1:0]   q_t, q_h;
    logic [DNUMW-1:0]   mean_t_w;
    logic signed [10:0] mean_t;
    logic [9:0]         mean_h;
    logic               rvalid_n;

    // offsets are applied at capture
    always_comb begin
        t_in = {i_raw_temp[10], i_raw_temp}
             + {{3{r_temp_offset[8]}}, r_temp_offset};
        h_in = $signed({2'b00, i_raw_humid})
             + {{3{r_humid_offset[8]}}, r_humid_offset};
    end

    // qualification, checks in priority order
    always_comb begin
        t_lo = {r_temp_lowest[10], r_temp_lowest};
        t_hi = {r_temp_highest[10], r_temp_highest};
        h_lo = $signed({2'b00, r_humid_lowest});
        h_hi = $signed({2'b00, r_humid_highest});
        dt   = {r_t[11], r_t} - {{2{r_prev_t[10]}}, r_prev_t};
        dh   = {r_h[11], r_h} - $signed({3'b000, r_prev_h});
        adt  = dt[12] ? 13'(-dt) : 13'(dt);
        adh  = dh[12] ? 13'(-dh) : 13'(dh);
        if (r_failed) begin
            reason = RSN_READ_FAIL;
        end else if (r_t < t_lo || r_t > t_hi) begin
            reason = RSN_TEMP_RANGE;
        end else if (r_h < h_lo || r_h > h_hi) begin
            reason = RSN_HUMID_RANGE;
        end else if (r_have_prev && adt > {2'b00, r_temp_step}) begin
            reason = RSN_TEMP_STEP;
        end else if (r_have_prev && adh > {2'b00, r_humid_step}) begin
            reason = RSN_HUMID_STEP;
        end else begin
            reason = RSN_OK;
        end
    end

    // ring and running sums
    always_comb begin
        if (r_h[11]) begin
            h_clamp = '0;
        end else if (r_h > $signed({2'b00, HUMID_MAX})) begin
            h_clamp = HUMID_MAX;
        end else begin
            h_clamp = r_h[9:0];
        end
        full    = (r_fill == CNTW'(WINDOW));
        t_sum_n = r_t_sum + {{(TSUMW-11){r_t[10]}}, r_t[10:0]}
                - (full ? {{(TSUMW-11){r_old_t[10]}}, r_old_t} : '0);
        h_sum_n = r_h_sum + HSUMW'(h_clamp) - (full ? HSUMW'(r_old_h) : '0);
        slot_n  = (r_slot == SLOTW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    end

    // divider operands: (2*|sum| + n) / (2*n)
    always_comb begin
        t_mag = r_t_sum[TSUMW-1] ? TSUMW'(-r_t_sum) : TSUMW'(r_t_sum);
        num_t = {t_mag, 1'b0} + DNUMW'(r_fill);
        num_h = DNUMW'({r_h_sum, 1'b0}) + DNUMW'(r_fill);
        den   = {r_fill, 1'b0};
    end

    thqa_div u_div_t (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step),
        .i_num  (num_t),
        .i_den  (den),
        .o_quot (q_t)
    );

    thqa_div u_div_h (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step),
        .i_num  (num_h),
        .i_den  (den),
        .o_quot (q_h)
    );

    always_comb begin
        mean_t_w = r_t_neg ? DNUMW'(-q_t) : q_t;
        mean_t   = $signed(mean_t_w[10:0]);
        mean_h   = q_h[9:0];
        rvalid_n = r_pass || (r_have_prev && r_err <= 8'(ERROR_LIMIT));
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_offset   <= '0;
            r_humid_offset  <= '0;
            r_temp_lowest   <= TEMP_LOWEST_RST;
            r_temp_highest  <= TEMP_HIGHEST_RST;
            r_humid_lowest  <= HUMID_LOWEST_RST;
            r_humid_highest <= HUMID_HIGHEST_RST;
            r_temp_step     <= TEMP_STEP_RST;
            r_humid_step    <= HUMID_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_OFFSET:   r_temp_offset   <= $signed(i_cfg_wdata[8:0]);
                CFG_HUMID_OFFSET:  r_humid_offset  <= $signed(i_cfg_wdata[8:0]);
                CFG_TEMP_LOWEST:   r_temp_lowest   <= $signed(i_cfg_wdata);
                CFG_TEMP_HIGHEST:  r_temp_highest  <= $signed(i_cfg_wdata);
                CFG_HUMID_LOWEST:  r_humid_lowest  <= i_cfg_wdata[9:0];
                CFG_HUMID_HIGHEST: r_humid_highest <= i_cfg_wdata[9:0];
                CFG_TEMP_STEP:     r_temp_step     <= i_cfg_wdata;
                CFG_HUMID_STEP:    r_humid_step    <= i_cfg_wdata;
            endcase
        end
    end

    // sample ring, read at capture and written on an accepted reading
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_old_t <= r_temp_ring[r_slot];
            r_old_h <= r_humid_ring[r_slot];
        end
        if (i_cmd.check && reason == RSN_OK) begin
            r_temp_ring[r_slot]  <= r_t[10:0];
            r_humid_ring[r_slot] <= h_clamp;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_failed <= i_read_failed;
            r_t      <= t_in;
            r_h      <= h_in;
        end
        if (i_cmd.check) begin
            r_reason <= reason;
        end
        if (i_cmd.load) begin
            r_t_neg <= r_t_sum[TSUMW-1];
        end
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_sum     <= '0;
            r_h_sum     <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_prev_t    <= '0;
            r_prev_h    <= '0;
            r_have_prev <= 1'b0;
            r_err       <= '0;
            r_pass      <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                r_pass <= (reason == RSN_OK);
                if (reason == RSN_OK) begin
                    r_t_sum <= t_sum_n;
                    r_h_sum <= h_sum_n;
                    r_slot  <= slot_n;
                    if (!full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_err <= '0;
                end else if (r_err != 8'hFF) begin
                    r_err <= r_err + 1'b1;
                end
            end
            if (i_cmd.finish && r_pass) begin
                r_prev_t    <= mean_t;
                r_prev_h    <= mean_h;
                r_have_prev <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_temp    <= r_pass ? mean_t : r_prev_t;
            r_o_humid   <= r_pass ? mean_h : r_prev_h;
            r_o_present <= r_pass || r_have_prev;
            r_o_rvalid  <= rvalid_n;
            r_o_reason  <= r_reason;
            r_o_err     <= r_err;
        end
    end

    assign o_sts.pass     = (reason == RSN_OK);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_temp_out      = r_o_temp;
    assign o_humid_out     = r_o_humid;
    assign o_value_present = r_o_present;
    assign o_reading_valid = r_o_rvalid;
    assign o_reject_reason = r_o_reason;
    assign o_error_run     = r_o_err;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNTW'(WINDOW))
        else $error("fill count beyond window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_pass) |-> (r_err == '0))
        else $error("error run not cleared on accepted reading");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_rvalid) |-> r_o_present)
        else $error("valid reading without a present value");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_reason == RSN_OK) |-> (r_o_rvalid && r_o_err == '0))
        else $error("accepted reading not reported valid");

endmodule

`default_nettype wire
